@@ sv/min_priority_queue_defines.svh @@
// Assertion macros shared by the priority queue RTL.
// Depends on a clk_i clock and an rst_ni active-low reset in the using module.
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define MPQ_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mpq_pkg.sv @@
// Types, codes and sizes shared by the priority queue modules.
// No dependencies.
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] OUT_INSERTED = 2'd0;
  localparam logic [1:0] OUT_REMOVED  = 2'd1;
  localparam logic [1:0] OUT_EMPTY    = 2'd2;
  localparam logic [1:0] OUT_FULL     = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] item_id;
    logic [15:0] item_key;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] out_id;
    logic [15:0] out_key;
    logic [4:0]  occupancy;
  } out_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] id;
  } entry_t;

  // What a cell hands to its right-hand neighbour each cycle.
  typedef struct packed {
    entry_t entry;
    logic   keep;
  } link_t;

  typedef struct packed {
    logic insert;
    logic remove;
    logic occupied;
  } cell_ctrl_t;

endpackage

@@ sv/min_priority_queue.sv @@
// Stable minimum priority queue built as a chain of compare-and-shift cells.
// An accepted input beat's result is in the output register in the next cycle.
// Throughput: one item a cycle unless the output stalls; every cell compares and shifts.
// Reset clears the entry count and the output valid; slot contents are not cleared.
// Depends on mpq_pkg, mpq_cell and min_priority_queue_defines.svh.
`timescale 1ns / 1ps
`include "min_priority_queue_defines.svh"

module min_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mpq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mpq_pkg::out_t out_data_o
);

  localparam int unsigned Depth = mpq_pkg::QUEUE_DEPTH;
  localparam int unsigned CntW  = mpq_pkg::CNT_W;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  mpq_pkg::out_t   out_q, out_d;

  logic accept, full, empty, do_ins, do_rem;
  logic [31:0] occ_wide;

  mpq_pkg::entry_t new_entry;
  mpq_pkg::link_t  links [Depth+1];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = (count_q == CntW'(Depth));
  assign empty      = (count_q == '0);
  assign do_ins     = accept && (in_data_i.op == mpq_pkg::OP_INSERT) && !full;
  assign do_rem     = accept && (in_data_i.op == mpq_pkg::OP_REMOVE) && !empty;

  assign new_entry.key = in_data_i.item_key;
  assign new_entry.id  = in_data_i.item_id;

  // The head of the chain always lets a new entry in ahead of the first slot.
  assign links[0].entry = '0;
  assign links[0].keep  = 1'b1;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    mpq_pkg::cell_ctrl_t ctrl;
    mpq_pkg::entry_t     next_entry;

    assign ctrl.insert   = do_ins;
    assign ctrl.remove   = do_rem;
    assign ctrl.occupied = (CntW'(i) < count_q);

    if (i == Depth - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = links[i+2].entry;
    end

    mpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_entry_i  (new_entry),
      .prev_i       (links[i]),
      .next_entry_i (next_entry),
      .link_o       (links[i+1])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign occ_wide = 32'(count_d);

  always_comb begin
    out_d           = out_q;
    out_valid_d     = out_valid_q & out_stall_i;
    if (accept) begin
      out_valid_d       = 1'b1;
      out_d.out_id      = '0;
      out_d.out_key     = '0;
      out_d.occupancy   = occ_wide[4:0];
      if (in_data_i.op == mpq_pkg::OP_INSERT) begin
        out_d.outcome = full ? mpq_pkg::OUT_FULL : mpq_pkg::OUT_INSERTED;
      end else if (empty) begin
        out_d.outcome = mpq_pkg::OUT_EMPTY;
      end else begin
        out_d.outcome = mpq_pkg::OUT_REMOVED;
        out_d.out_id  = links[1].entry.id;
        out_d.out_key = links[1].entry.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MPQ_ASSERT(a_count_bound, count_q <= CntW'(Depth), "entry count exceeds capacity")
  `MPQ_ASSERT_NEXT(a_ins_count, do_ins, count_q == $past(count_q) + CntW'(1),
                   "insert did not grow the count")
  `MPQ_ASSERT_NEXT(a_rem_count, do_rem, count_q == $past(count_q) - CntW'(1),
                   "remove did not shrink the count")
  `MPQ_ASSERT_NEXT(a_full_reject, accept && (in_data_i.op == mpq_pkg::OP_INSERT) && full,
                   out_valid_q && (out_q.outcome == mpq_pkg::OUT_FULL) &&
                   (count_q == $past(count_q)), "full insert was not rejected")
  `MPQ_ASSERT_NEXT(a_beat_held, out_valid_q && out_stall_i,
                   out_valid_q && (out_q == $past(out_q)), "stalled result beat changed")

endmodule

@@ sv/mpq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts it on insert or remove.
// Depends on mpq_pkg.
`timescale 1ns / 1ps

module mpq_cell (
  input  logic               clk_i,
  input  mpq_pkg::cell_ctrl_t ctrl_i,
  input  mpq_pkg::entry_t    new_entry_i,
  input  mpq_pkg::link_t     prev_i,
  input  mpq_pkg::entry_t    next_entry_i,
  output mpq_pkg::link_t     link_o
);

  mpq_pkg::entry_t entry_q;
  mpq_pkg::entry_t entry_d;
  logic            keep;

  // An entry with a key no greater than the new one stays put, so ties keep arrival order.
  assign keep = ctrl_i.occupied && (entry_q.key <= new_entry_i.key);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (keep) begin
        entry_d = entry_q;
      end else if (prev_i.keep) begin
        entry_d = new_entry_i;
      end else begin
        entry_d = prev_i.entry;
      end
    end else if (ctrl_i.remove) begin
      entry_d = next_entry_i;
    end
  end

  // The payload needs no reset; the fill count says which slots hold data.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.entry = entry_q;
  assign link_o.keep  = keep;

endmodule

@@ bench/min_priority_queue_tb.sv @@
// Self-checking bench for the stable minimum priority queue: random and directed beats
// with idling on both sides, checked against an in-bench sorted-list predictor.
// Depends on mpq_pkg and the min_priority_queue RTL only.
`timescale 1ns / 1ps

module min_priority_queue_tb;

  // Predicts the queue's answers and checks each delivered result against the oldest one due.
  class departure_checker;
    mpq_pkg::entry_t held[$];
    mpq_pkg::out_t   due_results[$];
    int unsigned     failures;

    function mpq_pkg::out_t predict_outcome(mpq_pkg::in_t item);
      mpq_pkg::out_t   res;
      mpq_pkg::entry_t fresh;
      int              pos;
      res = '0;
      if (item.op == mpq_pkg::OP_INSERT) begin
        if (held.size() >= mpq_pkg::QUEUE_DEPTH) begin
          res.outcome = mpq_pkg::OUT_FULL;
        end else begin
          // A new entry goes behind every held entry with an equal or smaller key.
          pos = 0;
          while (pos < held.size() && held[pos].key <= item.item_key) pos++;
          fresh.key = item.item_key;
          fresh.id  = item.item_id;
          held.insert(pos, fresh);
          res.outcome = mpq_pkg::OUT_INSERTED;
        end
      end else if (held.size() == 0) begin
        res.outcome = mpq_pkg::OUT_EMPTY;
      end else begin
        fresh       = held.pop_front();
        res.outcome = mpq_pkg::OUT_REMOVED;
        res.out_id  = fresh.id;
        res.out_key = fresh.key;
      end
      res.occupancy = 5'(held.size());
      return res;
    endfunction

    function void note_item(mpq_pkg::in_t item);
      due_results.push_back(predict_outcome(item));
    endfunction

    function void check_result(mpq_pkg::out_t got);
      mpq_pkg::out_t want;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: outcome %0d id %h key %h occupancy %0d",
                   got.outcome, got.out_id, got.out_key, got.occupancy);
        return;
      end
      want = due_results.pop_front();
      if (got.outcome !== want.outcome || got.out_id !== want.out_id ||
          got.out_key !== want.out_key || got.occupancy !== want.occupancy) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected outcome %0d id %h key %h occupancy %0d, got %0d %h %h %0d",
                   want.outcome, want.out_id, want.out_key, want.occupancy,
                   got.outcome, got.out_id, got.out_key, got.occupancy);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall_o;
  mpq_pkg::in_t  in_data = '0;
  logic          out_valid_o;
  logic          out_stall = 1'b0;
  mpq_pkg::out_t out_data_o;

  int unsigned src_idle_max = 15;
  int unsigned sink_idle_max = 15;
  int unsigned sink_hold_cycles = 0;

  departure_checker book;

  min_priority_queue i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[min_priority_queue] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) book.note_item(in_data);
      if (out_valid_o && !out_stall) book.check_result(out_data_o);
    end
  end

  // Result side: a random stall before each beat, or one long hold-off when asked for.
  initial begin : result_sink
    int unsigned wait_cycles;
    @(posedge rst_n);
    forever begin
      if (sink_hold_cycles != 0) begin
        wait_cycles      = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(sink_idle_max, 0);
      end
      if (wait_cycles != 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (wait_cycles - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  task automatic send_item(input mpq_pkg::in_t item);
    int unsigned gap;
    gap = $urandom_range(src_idle_max, 0);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall_o);
  endtask

  task automatic wait_drained();
    while (book.due_results.size() != 0) @(posedge clk);
  endtask

  function automatic mpq_pkg::in_t random_item(int unsigned insert_pct);
    mpq_pkg::in_t item;
    item.op      = ($urandom_range(99) < insert_pct) ? mpq_pkg::OP_INSERT : mpq_pkg::OP_REMOVE;
    item.item_id = 16'($urandom);
    case ($urandom_range(2))
      0: item.item_key = 16'($urandom);
      // A narrow key range makes ties common, which exercises the arrival-order rule.
      1: item.item_key = 16'($urandom_range(7));
      default: begin
        case ($urandom_range(3))
          0: item.item_key = 16'h0000;
          1: item.item_key = 16'hFFFF;
          2: item.item_key = 16'h8000;
          default: item.item_key = 16'h7FFF;
        endcase
      end
    endcase
    return item;
  endfunction

  initial begin : main_flow
    logic [15:0] fill_keys [16] = '{16'hFFFF, 16'h0000, 16'h1234, 16'h1234, 16'h1234,
                                    16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h0000,
                                    16'hFFFF, 16'h4000, 16'h1234, 16'h00FF, 16'hFF00,
                                    16'h0002};
    logic [15:0] fill_ids  [16] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001,
                                    16'h8000, 16'h7FFF, 16'h1111, 16'h2222, 16'h3333,
                                    16'h4444, 16'h6666, 16'h7777, 16'h9999, 16'hBBBB,
                                    16'hCCCC};
    mpq_pkg::in_t item;
    int unsigned  pct_table [6] = '{75, 50, 25, 90, 10, 50};
    int unsigned  insert_pct;

    book = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: remove from empty, fill to capacity with extreme and tied keys,
    // one rejected insert, then a few removes.
    send_item('{mpq_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF});
    for (int i = 0; i < 16; i++) send_item('{mpq_pkg::OP_INSERT, fill_ids[i], fill_keys[i]});
    send_item('{mpq_pkg::OP_INSERT, 16'hDEAD, 16'h0000});
    for (int i = 0; i < 3; i++) send_item('{mpq_pkg::OP_REMOVE, 16'h0000, 16'h0000});
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 27; phase++) begin
      insert_pct    = pct_table[phase % 6];
      src_idle_max  = (phase % 3 == 0) ? 0 : 15;
      sink_idle_max = (phase % 4 == 1) ? 0 : 15;
      if (phase == 4) begin
        // Result side holds off while beats keep arriving back to back, so the input
        // stalls behind the held result beat.
        insert_pct       = 90;
        src_idle_max     = 0;
        sink_hold_cycles = 100;
      end
      for (int n = 0; n < 50; n++) begin
        item = random_item(insert_pct);
        send_item(item);
      end
      if (phase % 4 == 3) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    if (book.failures == 0 && book.due_results.size() == 0) begin
      $display("[min_priority_queue] OK");
    end else begin
      $display("[min_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
